// File: rtl/fbfs_pkg.sv
// shared types and constants for the free block fit search table
`timescale 1ns / 1ps

package fbfs_pkg;

    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 7;

    // operation codes of an input item
    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // search policy codes, code 3 never finds a block
    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_WORST = 2'd1,
        FIT_BEST  = 2'd2
    } t_fit;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_PLACE = 5'b01000,
        ST_PUT   = 5'b10000
    } t_state;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] cap;
    } t_entry;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic strobe;
    } t_cmp_ctrl;

endpackage

// File: rtl/fbfs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fbfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fbfs_cmp.sv
// capacity compare unit that tracks the chosen entry during a search scan
`timescale 1ns / 1ps

module fbfs_cmp import fbfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fit              i_mode,
    input  logic [DATA_W-1:0] i_need,
    input  t_entry            i_entry,
    input  t_cmp_ctrl         i_ctrl,
    output logic              o_found,
    output t_entry            o_entry
);

    logic   r_have;
    t_entry r_best;
    logic   w_fits;
    logic   w_more;
    logic   w_less;
    logic   w_take;

    // magnitude compares on the entry being scanned
    assign w_fits = (i_entry.cap >= i_need);
    assign w_more = (i_entry.cap > r_best.cap);
    assign w_less = (i_entry.cap < r_best.cap);

    // policy decision, earliest entry wins on ties
    always_comb begin
        case (i_mode)
            FIT_FIRST: w_take = !r_have && w_fits;
            FIT_BEST:  w_take = w_fits && (!r_have || w_less);
            FIT_WORST: w_take = !r_have || w_more;
            default:   w_take = 1'b0;
        endcase
    end

    // have flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_have <= 1'b0;
        end else if (i_ctrl.strobe && w_take) begin
            r_have <= 1'b1;
        end
    end

    // chosen entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.strobe && w_take) begin
            r_best <= i_entry;
        end
    end

    // worst fit only qualifies the largest entry at the end
    always_comb begin
        case (i_mode)
            FIT_FIRST: o_found = r_have;
            FIT_BEST:  o_found = r_have;
            FIT_WORST: o_found = r_have && (r_best.cap >= i_need);
            default:   o_found = 1'b0;
        endcase
    end

    assign o_entry = r_best;

endmodule

// File: rtl/free_block_fit_search_table_top.sv
// Free block fit search table: sorted table of free blocks with fit searches.
// Input channel (i_in_valid / o_in_ready) carries one item: an insert of a
// block (address, capacity) or a search for request_size bytes. Output
// channel (o_out_valid / i_out_ready) returns one result item per input item.
// The user writes the fit policy via i_cfg_we / i_cfg_data only while idle (not enforced).
// Entries live in one ram of TABLE_ENTRIES words, one entry read per cycle.
// A search reads every held entry in order, none with an empty table.
// An insert walks down from the top entry, moving each larger address up one
// place per cycle; a dropped insert on a full table skips the walk.
// One item is in work at a time and o_in_ready is high only while the
// sequencer is idle.
// The result sits in an output register, so the next item may be accepted
// while the receiver stalls; a finished item waits for that register.
// Synchronous reset empties the table, clears the reuse counter and sets
// the policy to first fit; no clearing pass is needed.
`timescale 1ns / 1ps

module free_block_fit_search_table_top import fbfs_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  logic [DATA_W-1:0]        i_block_address,
    input  logic [DATA_W-1:0]        i_block_capacity,
    input  logic [DATA_W-1:0]        i_request_size,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_found,
    output logic [DATA_W-1:0]        o_found_address,
    output logic [DATA_W-1:0]        o_found_capacity,
    output logic [ENTRY_COUNT_W-1:0] o_entry_count,
    output logic                     o_insert_dropped,
    output logic [DATA_W-1:0]        o_reuse_total
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_reuse;
    t_fit              r_fit_mode;
    logic              r_op;
    logic              r_dropped;
    t_entry            r_new;
    logic [DATA_W-1:0] r_need;

    logic                     r_out_valid;
    logic                     r_out_found;
    t_entry                   r_out_entry;
    logic                     r_out_dropped;
    logic [ENTRY_COUNT_W-1:0] r_out_count;

    logic              w_in_acc;
    logic              w_full;
    logic              w_empty;
    logic [CNT_W-1:0]  w_last;
    logic [CNT_W-1:0]  w_ptr_dec;
    logic              w_ram_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    t_entry            w_rdata;
    logic              w_out_load;
    t_cmp_ctrl         w_cmp_ctrl;
    logic              w_cmp_found;
    t_entry            w_cmp_entry;
    logic              w_found;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == FULL_COUNT);
    assign w_empty    = (r_count == '0);
    assign w_last     = r_count - CNT_W'(1);
    assign w_ptr_dec  = r_ptr - CNT_W'(1);

    // entry store
    fbfs_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared compare unit for searches
    fbfs_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_fit_mode),
        .i_need  (r_need),
        .i_entry (w_rdata),
        .i_ctrl  (w_cmp_ctrl),
        .o_found (w_cmp_found),
        .o_entry (w_cmp_entry)
    );

    // sequencer
    always_comb begin
        n_state           = r_state;
        n_ptr             = r_ptr;
        n_pend            = 1'b0;
        w_ram_we          = 1'b0;
        w_waddr           = '0;
        w_wdata           = r_new;
        w_raddr           = r_ptr[IDX_W-1:0];
        w_out_load        = 1'b0;
        w_cmp_ctrl.clear  = 1'b0;
        w_cmp_ctrl.strobe = r_pend && (r_state == ST_SCAN);
        case (r_state)
            ST_IDLE: begin
                // prefetch the top entry for an insert walk
                w_raddr = w_last[IDX_W-1:0];
                if (w_in_acc) begin
                    if (i_operation == OP_INSERT) begin
                        if (w_full) begin
                            n_state = ST_PUT;
                        end else if (w_empty) begin
                            n_state = ST_PLACE;
                        end else begin
                            n_ptr   = w_last;
                            n_state = ST_SHIFT;
                        end
                    end else begin
                        w_cmp_ctrl.clear = 1'b1;
                        n_ptr            = '0;
                        n_state          = w_empty ? ST_PUT : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // one read per cycle, compare in the cycle after the read
                if (r_ptr < r_count) begin
                    n_ptr  = r_ptr + CNT_W'(1);
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_PUT;
                end
            end
            ST_SHIFT: begin
                // move larger addresses up one place, place the new block below
                w_ram_we = 1'b1;
                w_waddr  = r_ptr[IDX_W-1:0] + IDX_W'(1);
                if (w_rdata.addr > r_new.addr) begin
                    w_wdata = w_rdata;
                    w_raddr = w_ptr_dec[IDX_W-1:0];
                    if (r_ptr == '0) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_ptr = w_ptr_dec;
                    end
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_PLACE: begin
                w_ram_we = 1'b1;
                w_waddr  = '0;
                n_state  = ST_PUT;
            end
            ST_PUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pend  <= n_pend;
        end
    end

    // policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_FIRST;
        end else if (i_cfg_we) begin
            r_fit_mode <= t_fit'(i_cfg_data);
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_in_acc && (i_operation == OP_INSERT) && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= i_operation;
            r_new     <= '{addr: i_block_address, cap: i_block_capacity};
            r_need    <= i_request_size;
            r_dropped <= (i_operation == OP_INSERT) && w_full;
        end
    end

    assign w_found = (r_op == OP_SEARCH) && w_cmp_found;

    // reuse counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reuse <= '0;
        end else if (w_out_load && w_found) begin
            r_reuse <= r_reuse + DATA_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result fields, count held with the item it belongs to
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found   <= w_found;
            r_out_entry   <= w_found ? w_cmp_entry : '0;
            r_out_dropped <= r_dropped;
            r_out_count   <= ENTRY_COUNT_W'(r_count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_found;
    assign o_found_address  = r_out_entry.addr;
    assign o_found_capacity = r_out_entry.cap;
    assign o_entry_count    = r_out_count;
    assign o_insert_dropped = r_out_dropped;
    assign o_reuse_total    = r_reuse;

`ifndef SYNTH
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above table depth");

    // count moves only on an accepted insert
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_count))
        else $error("entry count changed without an insert");

    // a full table refuses an insert and stays full
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_operation == OP_INSERT) && w_full)
        |=> (r_count == FULL_COUNT) && r_dropped)
        else $error("insert on full table not dropped");

    // a found result never comes with a dropped flag
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_insert_dropped))
        else $error("found and dropped both set");

    // reuse counter steps only when a found result is loaded
    a_reuse_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_out_load && w_found) |=> $stable(r_reuse))
        else $error("reuse counter moved without a found search");
`endif

endmodule

// File: dv/fbfs_checker.sv
// checker for the free block fit search table: tracks the table and compares result items
`timescale 1ns / 1ps

module fbfs_checker import fbfs_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_operation,
    input  logic [DATA_W-1:0]        i_block_address,
    input  logic [DATA_W-1:0]        i_block_capacity,
    input  logic [DATA_W-1:0]        i_request_size,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_found,
    input  logic [DATA_W-1:0]        i_found_address,
    input  logic [DATA_W-1:0]        i_found_capacity,
    input  logic [ENTRY_COUNT_W-1:0] i_entry_count,
    input  logic                     i_insert_dropped,
    input  logic [DATA_W-1:0]        i_reuse_total,
    output int                       o_mismatch_count,
    output int                       o_outstanding
);

    // one result item as the table should answer it
    typedef struct packed {
        logic                     found;
        logic [DATA_W-1:0]        addr;
        logic [DATA_W-1:0]        cap;
        logic [ENTRY_COUNT_W-1:0] count;
        logic                     dropped;
        logic [DATA_W-1:0]        reuse;
    } t_response;

    // shadow copy of the free block table
    logic [DATA_W-1:0] addr_tab [TABLE_ENTRIES];
    logic [DATA_W-1:0] cap_tab  [TABLE_ENTRIES];
    int                held;
    logic [DATA_W-1:0] reuse_cnt;
    logic [1:0]        mode;

    t_response table_responses [$];
    t_response head;
    int        mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    // apply one item to the shadow table and return the answer it should get
    function automatic t_response model_table_op(input logic op,
                                                 input logic [DATA_W-1:0] addr,
                                                 input logic [DATA_W-1:0] cap,
                                                 input logic [DATA_W-1:0] need);
        t_response r;
        int        pos;
        int        sel;
        bit        have;
        r    = '0;
        have = 1'b0;
        sel  = 0;
        if (op == OP_INSERT) begin
            if (held >= TABLE_ENTRIES) begin
                r.dropped = 1'b1;
            end else begin
                // sorted place: in front of the first strictly greater address
                pos = held;
                for (int i = 0; i < held; i++) begin
                    if (addr_tab[i] > addr) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = held; i > pos; i--) begin
                    addr_tab[i] = addr_tab[i-1];
                    cap_tab[i]  = cap_tab[i-1];
                end
                addr_tab[pos] = addr;
                cap_tab[pos]  = cap;
                held++;
            end
        end else begin
            case (mode)
                FIT_FIRST: begin
                    for (int i = 0; i < held; i++) begin
                        if (cap_tab[i] >= need) begin
                            sel  = i;
                            have = 1'b1;
                            break;
                        end
                    end
                end
                FIT_BEST: begin
                    for (int i = 0; i < held; i++) begin
                        if (cap_tab[i] >= need && (!have || cap_tab[i] < cap_tab[sel])) begin
                            sel  = i;
                            have = 1'b1;
                        end
                    end
                end
                FIT_WORST: begin
                    // largest entry first, then the size test
                    if (held > 0) begin
                        for (int i = 1; i < held; i++) begin
                            if (cap_tab[i] > cap_tab[sel]) sel = i;
                        end
                        have = (cap_tab[sel] >= need);
                    end
                end
                default: have = 1'b0;
            endcase
            if (have) begin
                r.found   = 1'b1;
                r.addr    = addr_tab[sel];
                r.cap     = cap_tab[sel];
                reuse_cnt = reuse_cnt + 1'b1;
            end
        end
        r.count = ENTRY_COUNT_W'(held);
        r.reuse = reuse_cnt;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // watch both channels; the older result item is checked before a new item is modeled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held      = 0;
            reuse_cnt = '0;
            mode      = FIT_FIRST;
            table_responses.delete();
        end else begin
            if (i_cfg_we) mode = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (table_responses.size() == 0) begin
                    $display("%0t: result item with no item outstanding, expected none, got %0h",
                             $time, i_found_address);
                    mismatch_count++;
                end else begin
                    head = table_responses.pop_front();
                    check_field("found", DATA_W'(head.found), DATA_W'(i_found));
                    check_field("found_address", head.addr, i_found_address);
                    check_field("found_capacity", head.cap, i_found_capacity);
                    check_field("entry_count", DATA_W'(head.count), DATA_W'(i_entry_count));
                    check_field("insert_dropped", DATA_W'(head.dropped),
                                DATA_W'(i_insert_dropped));
                    check_field("reuse_total", head.reuse, i_reuse_total);
                end
            end
            if (i_in_valid && i_in_ready) begin
                table_responses.push_back(model_table_op(i_operation, i_block_address,
                                                         i_block_capacity, i_request_size));
            end
        end
        o_outstanding <= table_responses.size();
    end

endmodule

// File: dv/tb.sv
// testbench top for the free block fit search table: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
    import fbfs_pkg::*;

    localparam int         TABLE_ENTRIES   = 64;
    localparam logic [1:0] FIT_UNUSED      = 2'd3;
    localparam int         RANDOM_SEGMENTS = 12;
    localparam int         SEGMENT_ITEMS   = 155;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         INSERT_PCT      = 8;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_cfg_we         = 1'b0;
    logic [1:0]               i_cfg_data       = '0;
    logic                     i_in_valid       = 1'b0;
    logic                     i_operation      = OP_SEARCH;
    logic [DATA_W-1:0]        i_block_address  = '0;
    logic [DATA_W-1:0]        i_block_capacity = '0;
    logic [DATA_W-1:0]        i_request_size   = '0;
    logic                     i_out_ready      = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic                     o_found;
    logic [DATA_W-1:0]        o_found_address;
    logic [DATA_W-1:0]        o_found_capacity;
    logic [ENTRY_COUNT_W-1:0] o_entry_count;
    logic                     o_insert_dropped;
    logic [DATA_W-1:0]        o_reuse_total;

    int mismatch_count;
    int outstanding;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    // addresses and capacities already offered, reused to hit ties and edges
    logic [DATA_W-1:0] addr_pool [$];
    logic [DATA_W-1:0] cap_pool  [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    free_block_fit_search_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_block_address (i_block_address),
        .i_block_capacity(i_block_capacity),
        .i_request_size  (i_request_size),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_found_address (o_found_address),
        .o_found_capacity(o_found_capacity),
        .o_entry_count   (o_entry_count),
        .o_insert_dropped(o_insert_dropped),
        .o_reuse_total   (o_reuse_total)
    );

    fbfs_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_block_address (i_block_address),
        .i_block_capacity(i_block_capacity),
        .i_request_size  (i_request_size),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_found         (o_found),
        .i_found_address (o_found_address),
        .i_found_capacity(o_found_capacity),
        .i_entry_count   (o_entry_count),
        .i_insert_dropped(o_insert_dropped),
        .i_reuse_total   (o_reuse_total),
        .o_mismatch_count(mismatch_count),
        .o_outstanding   (outstanding)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // run limit
    initial begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // offer one item, with random idle cycles ahead of it
    task automatic offer_item(input logic op, input logic [DATA_W-1:0] addr,
                              input logic [DATA_W-1:0] cap, input logic [DATA_W-1:0] need);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_block_address  <= addr;
        i_block_capacity <= cap;
        i_request_size   <= need;
        if (op == OP_INSERT) begin
            addr_pool.push_back(addr);
            cap_pool.push_back(cap);
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait for every result item
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // policy write, only with the block idle
    task automatic set_fit_mode(input logic [1:0] mode);
        drain_results();
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random item: mostly searches aimed at held sizes, occasional inserts
    task automatic offer_random_item();
        logic              op;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] cap;
        logic [DATA_W-1:0] need;
        int                pick;
        op   = ($urandom_range(99) < INSERT_PCT) ? OP_INSERT : OP_SEARCH;
        addr = $urandom();
        cap  = $urandom();
        need = $urandom();
        pick = $urandom_range(99);
        if (op == OP_INSERT) begin
            if (pick < 25) addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
            else if (pick < 50) addr = $urandom_range(4095);
            pick = $urandom_range(99);
            if (pick < 30) cap = cap_pool[$urandom_range(cap_pool.size() - 1)];
            else if (pick < 60) cap = $urandom_range(63);
        end else begin
            if (pick < 35) need = cap_pool[$urandom_range(cap_pool.size() - 1)];
            else if (pick < 50) need = cap_pool[$urandom_range(cap_pool.size() - 1)] + 1'b1;
            else if (pick < 60) need = cap_pool[$urandom_range(cap_pool.size() - 1)] - 1'b1;
            else if (pick < 65) need = '0;
            else if (pick < 70) need = '1;
            else if (pick < 75) need = $urandom_range(63);
        end
        offer_item(op, addr, cap, need);
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // searches on an empty table under every policy
        set_fit_mode(FIT_FIRST);
        offer_item(OP_SEARCH, '0, '0, '0);
        offer_item(OP_SEARCH, '1, '1, '1);
        set_fit_mode(FIT_WORST);
        offer_item(OP_SEARCH, '0, '0, '0);
        set_fit_mode(FIT_BEST);
        offer_item(OP_SEARCH, '0, '0, 32'd5);
        set_fit_mode(FIT_UNUSED);
        offer_item(OP_SEARCH, '0, '0, '0);

        // small table with an equal address and a capacity tie
        offer_item(OP_INSERT, 32'h0000_1000, 32'h100, '0);
        offer_item(OP_INSERT, '0, '0, '0);
        offer_item(OP_INSERT, 32'h0000_1000, 32'h80, '0);
        offer_item(OP_INSERT, 32'h0000_0800, 32'h100, '0);
        offer_item(OP_SEARCH, '0, '0, '0);

        // worst, best and first fit with and without a hit
        set_fit_mode(FIT_WORST);
        offer_item(OP_SEARCH, '0, '0, 32'h200);
        offer_item(OP_SEARCH, '0, '0, 32'h100);
        set_fit_mode(FIT_BEST);
        offer_item(OP_SEARCH, '0, '0, 32'h101);
        offer_item(OP_SEARCH, '0, '0, 32'h81);
        set_fit_mode(FIT_FIRST);
        offer_item(OP_SEARCH, '0, '0, 32'h81);
        offer_item(OP_SEARCH, '0, '0, 32'h101);

        // largest capacity twice, at the top address and in the middle
        offer_item(OP_INSERT, '1, '1, '0);
        offer_item(OP_INSERT, 32'h0000_2000, '1, '0);
        offer_item(OP_SEARCH, '0, '0, '1);
        offer_item(OP_SEARCH, '0, '0, '0);
        set_fit_mode(FIT_WORST);
        offer_item(OP_SEARCH, '0, '0, '0);
        set_fit_mode(FIT_BEST);
        offer_item(OP_SEARCH, '0, '0, '1);
        offer_item(OP_SEARCH, '0, '0, '0);

        // random segments, crossing policy with idling phase
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            if (seg == 10) begin
                set_fit_mode(FIT_UNUSED);
            end else begin
                case (seg % 3)
                    0:       set_fit_mode(FIT_FIRST);
                    1:       set_fit_mode(FIT_WORST);
                    default: set_fit_mode(FIT_BEST);
                endcase
            end
            case (seg % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 52;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 52;
                end
                default: begin
                    tx_idle_pct  = 38;
                    rx_stall_pct = 38;
                end
            endcase
            // long receiver hold-off while items keep coming
            if (seg == 4) rx_hold_left = HOLD_CYCLES;
            repeat (SEGMENT_ITEMS) offer_random_item();
        end

        drain_results();
        repeat (70) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
